[rtl/u2u8_pkg.sv]
// shared types, constants and byte encoding for the utf-16 to utf-8 encoder
package u2u8_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] LEAD_LO  = 16'hD800;
  localparam logic [15:0] LEAD_HI  = 16'hDBFF;
  localparam logic [15:0] TRAIL_LO = 16'hDC00;
  localparam logic [15:0] TRAIL_HI = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [7:0] PFX_CONT = 8'h80;
  localparam logic [7:0] PFX_TWO  = 8'hC0;
  localparam logic [7:0] PFX_THREE = 8'hE0;
  localparam logic [7:0] PFX_FOUR = 8'hF0;

  localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

  // one queue entry: all bytes that one code unit gives, in output order
  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [2:0]      count;   // 0 means count-only end result
    logic [31:0]     base;    // bytes written before this entry
    logic            eos;
  } job_t;

  // utf-8 bytes of a code point of length n, first byte at index 0
  function automatic logic [3:0][7:0] encode_cp(input logic [20:0] cp, input logic [2:0] n);
    logic [3:0][7:0] b;
    b = '0;
    unique case (n)
      3'd1: begin
        b[0] = cp[7:0];
      end
      3'd2: begin
        b[0] = PFX_TWO  | {3'b000, cp[10:6]};
        b[1] = PFX_CONT | {2'b00, cp[5:0]};
      end
      3'd3: begin
        b[0] = PFX_THREE | {4'b0000, cp[15:12]};
        b[1] = PFX_CONT  | {2'b00, cp[11:6]};
        b[2] = PFX_CONT  | {2'b00, cp[5:0]};
      end
      3'd4: begin
        b[0] = PFX_FOUR | {5'b00000, cp[20:18]};
        b[1] = PFX_CONT | {2'b00, cp[17:12]};
        b[2] = PFX_CONT | {2'b00, cp[11:6]};
        b[3] = PFX_CONT | {2'b00, cp[5:0]};
      end
      default: begin
        b = '0;
      end
    endcase
    return b;
  endfunction

endpackage

[rtl/u2u8_ifs.sv]
// channel interfaces: code unit input, byte output, limit register write
interface utf_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_string;

  modport source (output valid, output code_unit, output end_of_string, input ready);
  modport sink (input valid, input code_unit, input end_of_string, output ready);
endinterface

interface utf_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic        byte_valid;
  logic        last_of_run;
  logic        string_done;
  logic [31:0] total_bytes;

  modport source (output valid, output byte_value, output byte_valid, output last_of_run,
                  output string_done, output total_bytes, input ready);
  modport sink (input valid, input byte_value, input byte_valid, input last_of_run,
                input string_done, input total_bytes, output ready);
endinterface

interface utf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] byte_limit;

  modport source (output valid, output byte_limit, input ready);
  modport sink (input valid, input byte_limit, output ready);
endinterface

[rtl/u2u8_queue.sv]
// small job queue between the front classifier and the byte sequencer
module u2u8_queue
  import u2u8_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_data,
  output logic full,
  input  logic pop,
  output job_t rd_data,
  output logic empty
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/u2u8_front.sv]
// front end: surrogate pairing, limit check and string state, at most one job per code unit
module u2u8_front
  import u2u8_pkg::*;
(
  input  logic clk,
  input  logic rst,
  utf_unit_if.sink unit_in,
  utf_cfg_if.sink  cfg,
  output logic push,
  output job_t job,
  input  logic q_full
);

  logic [31:0] byte_limit;
  logic [15:0] pending_lead;
  logic        lead_held;
  logic [31:0] bytes_written;
  logic        halted;

  logic        lead_held_next;
  logic [31:0] bytes_written_next;
  logic        halted_next;
  logic        hold_unit;

  logic        accept;
  logic [15:0] cu;
  logic        is_lead;
  logic        is_trail;
  logic [2:0]  n_unit;
  logic [20:0] pair_cp;
  logic [32:0] lim;
  logic        fit_pair;
  logic        fit_lead;
  logic        fit_unit;
  logic        fit_lead_unit;
  logic        lead_send;
  logic        main_send;
  logic [20:0] main_cp;
  logic [2:0]  main_n;
  logic [2:0]  count;
  logic [3:0][7:0] lead_bytes;
  logic [3:0][7:0] main_bytes;

  assign unit_in.ready = !q_full;
  assign cfg.ready     = 1'b1;
  assign accept        = unit_in.valid && !q_full;

  assign cu       = unit_in.code_unit;
  assign is_lead  = (cu >= LEAD_LO) && (cu <= LEAD_HI);
  assign is_trail = (cu >= TRAIL_LO) && (cu <= TRAIL_HI);
  assign n_unit   = (cu <= 16'h007F) ? 3'd1 : (cu <= 16'h07FF) ? 3'd2 : 3'd3;
  assign pair_cp  = {1'b0, pending_lead[9:0], cu[9:0]} + SUPP_BASE;

  // all limit checks side by side from the same count, no chained adds
  assign lim           = {1'b0, byte_limit};
  assign fit_pair      = ({1'b0, bytes_written} + 33'd4) <= lim;
  assign fit_lead      = ({1'b0, bytes_written} + 33'd3) <= lim;
  assign fit_unit      = ({1'b0, bytes_written} + {30'b0, n_unit}) <= lim;
  assign fit_lead_unit = ({1'b0, bytes_written} + {29'b0, {1'b0, n_unit} + 4'd3}) <= lim;

  always_comb begin
    lead_send   = 1'b0;
    main_send   = 1'b0;
    main_cp     = {5'b0, cu};
    main_n      = n_unit;
    hold_unit   = 1'b0;
    halted_next = halted;
    if (!halted) begin
      if (lead_held && is_trail) begin
        main_cp     = pair_cp;
        main_n      = 3'd4;
        main_send   = fit_pair;
        halted_next = !fit_pair;
      end else if (lead_held) begin
        lead_send = fit_lead;
        if (!fit_lead) begin
          halted_next = 1'b1;
        end else if (is_lead && !unit_in.end_of_string) begin
          hold_unit = 1'b1;
        end else begin
          main_send   = fit_lead_unit;
          halted_next = !fit_lead_unit;
        end
      end else if (is_lead && !unit_in.end_of_string) begin
        hold_unit = 1'b1;
      end else begin
        main_send   = fit_unit;
        halted_next = !fit_unit;
      end
    end
  end

  assign count = (lead_send ? 3'd3 : 3'd0) + (main_send ? main_n : 3'd0);

  assign lead_bytes = encode_cp({5'b0, pending_lead}, 3'd3);
  assign main_bytes = encode_cp(main_cp, main_n);

  always_comb begin
    job.bytes = '0;
    if (lead_send) begin
      job.bytes[2:0] = lead_bytes[2:0];
      job.bytes[5:3] = main_bytes[2:0];
    end else begin
      job.bytes[3:0] = main_bytes;
    end
    job.count = count;
    job.base  = bytes_written;
    job.eos   = unit_in.end_of_string;
  end

  assign push = accept && ((count != 3'd0) || unit_in.end_of_string);

  always_comb begin
    lead_held_next     = lead_held;
    bytes_written_next = bytes_written;
    if (accept) begin
      if (unit_in.end_of_string) begin
        lead_held_next     = 1'b0;
        bytes_written_next = '0;
      end else begin
        lead_held_next     = hold_unit;
        bytes_written_next = bytes_written + {29'b0, count};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_unit) begin
      pending_lead <= cu;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit    <= LIMIT_RESET;
      lead_held     <= 1'b0;
      bytes_written <= '0;
      halted        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        byte_limit <= cfg.byte_limit;
      end
      lead_held     <= lead_held_next;
      bytes_written <= bytes_written_next;
      if (accept) begin
        halted <= unit_in.end_of_string ? 1'b0 : halted_next;
      end
    end
  end

endmodule

[rtl/u2u8_back.sv]
// back end: walks the queued job one byte per cycle into the output register while the output is taken
module u2u8_back
  import u2u8_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  job_t head,
  input  logic q_empty,
  output logic pop,
  utf_byte_if.source byte_out
);

  logic [2:0]  idx;
  logic [2:0]  n_res;
  logic        last;
  logic        advance;
  logic        out_valid;
  logic [7:0]  byte_value;
  logic        byte_valid;
  logic        last_of_run;
  logic        string_done;
  logic [31:0] total_bytes;

  assign n_res   = (head.count == 3'd0) ? 3'd1 : head.count;
  assign last    = (idx == n_res - 3'd1);
  assign advance = !q_empty && (!out_valid || byte_out.ready);
  assign pop     = advance && last;

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_valid  <= (head.count != 3'd0);
      byte_value  <= (head.count != 3'd0) ? head.bytes[idx] : 8'h00;
      last_of_run <= last;
      string_done <= last && head.eos;
      total_bytes <= (head.count != 3'd0) ? head.base + {29'b0, idx} + 32'd1 : head.base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= last ? 3'd0 : idx + 3'd1;
      end else if (byte_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign byte_out.valid       = out_valid;
  assign byte_out.byte_value  = byte_value;
  assign byte_out.byte_valid  = byte_valid;
  assign byte_out.last_of_run = last_of_run;
  assign byte_out.string_done = string_done;
  assign byte_out.total_bytes = total_bytes;

endmodule

[rtl/utf16_to_utf8_encoder.sv]
// utf-16 to utf-8 encoder top level: front end, job queue, byte sequencer
// the first result of a code unit is written into the job queue and then into the output register
// throughput: one output byte per cycle while the receiver is ready; a unit gives up to six results
// (3 for most bmp text), all through the single byte-wide output register
// reset: clears the string state and the queue, byte_limit returns to all ones
module utf16_to_utf8_encoder
  import u2u8_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input logic clk,
  input logic rst,
  utf_unit_if.sink   unit_in,
  utf_cfg_if.sink    cfg,
  utf_byte_if.source byte_out
);

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t job;
  job_t head;

  u2u8_front u_front (
    .clk     (clk),
    .rst     (rst),
    .unit_in (unit_in),
    .cfg     (cfg),
    .push    (push),
    .job     (job),
    .q_full  (q_full)
  );

  u2u8_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (job),
    .full    (q_full),
    .pop     (pop),
    .rd_data (head),
    .empty   (q_empty)
  );

  u2u8_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .byte_out (byte_out)
  );

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// self-checking bench for the utf-16 to utf-8 encoder with randomized strings and byte limits
module tb_top;
  import u2u8_pkg::*;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
    logic [4:0]  gap;
  } unit_item_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic        byte_valid;
    logic        last_of_run;
    logic        string_done;
    logic [31:0] total_bytes;
  } utf8_byte_t;

  typedef enum logic [2:0] {
    UK_ASCII, UK_TWO, UK_THREE, UK_SUPP, UK_LEAD, UK_TRAIL, UK_ANY
  } unit_kind_t;

  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] UTF8_TWO   = 8'hC0;
  localparam logic [7:0] UTF8_THREE = 8'hE0;
  localparam logic [7:0] UTF8_FOUR  = 8'hF0;
  localparam int MAX_GAP = 19;
  localparam int SETTLE_CYCLES = 12;

  logic clk;
  logic rst;

  utf_unit_if unit_if ();
  utf_byte_if byte_if ();
  utf_cfg_if  cfg_if ();

  utf16_to_utf8_encoder uut (
    .clk      (clk),
    .rst      (rst),
    .unit_in  (unit_if),
    .cfg      (cfg_if),
    .byte_out (byte_if)
  );

  // pending code units and expected utf-8 output
  unit_item_t code_units_q[$];
  utf8_byte_t utf8_pending[$];
  utf8_byte_t run_q[$];

  // encoder state as seen by the predictor
  logic [31:0] limit_reg;
  logic [15:0] lead_pending;
  logic        held_lead;
  logic [31:0] string_bytes;
  logic        string_halted;

  int errors;
  int units_sent;
  int strings_seen;
  int bytes_checked;
  int count_only_seen;
  int halts;
  int limit_writes;

  int tx_gap_max;
  int rx_gap_max;

  // driver state
  unit_item_t tx_cur;
  logic       tx_have;
  int         tx_delay;

  // monitor state
  int         rx_delay;
  utf8_byte_t rx_got;
  utf8_byte_t rx_want;

  // long receiver hold-off, requested by the stimulus
  int stall_req;
  int stall_ack;
  int stall_len;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic string describe(input utf8_byte_t r);
    return $sformatf("byte=%02h valid=%b last=%b done=%b total=%0d",
                     r.byte_value, r.byte_valid, r.last_of_run, r.string_done, r.total_bytes);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    string_bytes = string_bytes + 1;
    run_q.push_back('{byte_value: b, byte_valid: 1'b1, last_of_run: 1'b0,
                      string_done: 1'b0, total_bytes: string_bytes});
  endtask

  task automatic emit_code_point(input logic [20:0] cp);
    logic [2:0] n;
    if (string_halted) return;
    if (cp <= 21'h7F) n = 3'd1;
    else if (cp <= 21'h7FF) n = 3'd2;
    else if (cp <= 21'hFFFF) n = 3'd3;
    else n = 3'd4;
    // sum formed at 33 bits so it cannot wrap
    if ({1'b0, string_bytes} + 33'(n) > {1'b0, limit_reg}) begin
      string_halted = 1'b1;
      held_lead = 1'b0;
      lead_pending = '0;
      halts++;
      return;
    end
    case (n)
      3'd1: put_byte(cp[7:0]);
      3'd2: begin
        put_byte(UTF8_TWO | {3'b000, cp[10:6]});
        put_byte(UTF8_CONT | {2'b00, cp[5:0]});
      end
      3'd3: begin
        put_byte(UTF8_THREE | {4'b0000, cp[15:12]});
        put_byte(UTF8_CONT | {2'b00, cp[11:6]});
        put_byte(UTF8_CONT | {2'b00, cp[5:0]});
      end
      default: begin
        put_byte(UTF8_FOUR | {5'b00000, cp[20:18]});
        put_byte(UTF8_CONT | {2'b00, cp[17:12]});
        put_byte(UTF8_CONT | {2'b00, cp[11:6]});
        put_byte(UTF8_CONT | {2'b00, cp[5:0]});
      end
    endcase
  endtask

  task automatic encode_unit(input logic [15:0] cu, input logic eos);
    logic        is_lead;
    logic        is_trail;
    logic        paired;
    logic [15:0] lead;
    is_lead = (cu >= LEAD_LO) && (cu <= LEAD_HI);
    is_trail = (cu >= TRAIL_LO) && (cu <= TRAIL_HI);
    paired = 1'b0;
    run_q = {};
    if (!string_halted) begin
      if (held_lead) begin
        lead = lead_pending;
        held_lead = 1'b0;
        lead_pending = '0;
        if (is_trail) begin
          emit_code_point(SUPP_BASE + {1'b0, lead[9:0], cu[9:0]});
          paired = 1'b1;
        end else begin
          emit_code_point({5'b0, lead});
        end
      end
      if (!paired) begin
        if (is_lead && !eos && !string_halted) begin
          lead_pending = cu;
          held_lead = 1'b1;
        end else begin
          emit_code_point({5'b0, cu});
        end
      end
    end
    if (eos) begin
      if (run_q.size() == 0)
        run_q.push_back('{byte_value: 8'h00, byte_valid: 1'b0, last_of_run: 1'b0,
                          string_done: 1'b0, total_bytes: string_bytes});
      run_q[run_q.size() - 1].string_done = 1'b1;
      lead_pending = '0;
      held_lead = 1'b0;
      string_bytes = '0;
      string_halted = 1'b0;
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
    foreach (run_q[i]) utf8_pending.push_back(run_q[i]);
  endtask

  // unit driver
  always @(posedge clk) begin
    if (rst) begin
      unit_if.valid <= 1'b0;
      unit_if.code_unit <= '0;
      unit_if.end_of_string <= 1'b0;
      tx_have = 1'b0;
      tx_delay = 0;
    end else begin
      if (unit_if.valid && unit_if.ready) begin
        encode_unit(unit_if.code_unit, unit_if.end_of_string);
        units_sent++;
      end
      if (!unit_if.valid || unit_if.ready) begin
        if (!tx_have && code_units_q.size() > 0) begin
          tx_cur = code_units_q.pop_front();
          tx_delay = tx_cur.gap;
          tx_have = 1'b1;
        end
        if (tx_have && tx_delay == 0) begin
          unit_if.valid <= 1'b1;
          unit_if.code_unit <= tx_cur.code_unit;
          unit_if.end_of_string <= tx_cur.end_of_string;
          tx_have = 1'b0;
        end else begin
          unit_if.valid <= 1'b0;
          if (tx_have) tx_delay--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_ack <= 0;
      stall_left <= 0;
    end else if (stall_ack != stall_req) begin
      stall_ack <= stall_req;
      stall_left <= stall_len;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // byte monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      byte_if.ready <= 1'b0;
      rx_delay = 0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        rx_got = '{byte_value: byte_if.byte_value, byte_valid: byte_if.byte_valid,
                   last_of_run: byte_if.last_of_run, string_done: byte_if.string_done,
                   total_bytes: byte_if.total_bytes};
        if (rx_got.byte_valid) bytes_checked++;
        else count_only_seen++;
        if (rx_got.string_done) strings_seen++;
        if (utf8_pending.size() == 0) begin
          note_error($sformatf("unexpected transaction: %s", describe(rx_got)));
        end else begin
          rx_want = utf8_pending.pop_front();
          if (rx_got !== rx_want)
            note_error($sformatf("expected %s, got %s", describe(rx_want), describe(rx_got)));
        end
        rx_delay = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
      end
      if (stall_left != 0 || stall_ack != stall_req) begin
        byte_if.ready <= 1'b0;
      end else if (rx_delay > 0) begin
        byte_if.ready <= 1'b0;
        rx_delay--;
      end else begin
        byte_if.ready <= 1'b1;
      end
    end
  end

  task automatic queue_unit(input logic [15:0] cu, input logic eos);
    unit_item_t item;
    item.code_unit = cu;
    item.end_of_string = eos;
    item.gap = (tx_gap_max > 0) ? 5'($urandom_range(0, tx_gap_max)) : 5'd0;
    code_units_q.push_back(item);
  endtask

  // well-formed text picks among real characters, noise also allows lone surrogates
  task automatic add_string(input int len, input bit clean, input bit close, output int added);
    logic [15:0] units[$];
    unit_kind_t  kind;
    units = {};
    while (units.size() < len) begin
      if (clean) kind = unit_kind_t'($urandom_range(UK_ASCII, UK_SUPP));
      else kind = unit_kind_t'($urandom_range(UK_ASCII, UK_ANY));
      case (kind)
        UK_ASCII: units.push_back(16'($urandom_range(0, 'h7F)));
        UK_TWO:   units.push_back(16'($urandom_range('h80, 'h7FF)));
        UK_THREE: begin
          if ($urandom_range(0, 1)) units.push_back(16'($urandom_range('h800, 'hD7FF)));
          else units.push_back(16'($urandom_range('hE000, 'hFFFF)));
        end
        UK_SUPP: begin
          units.push_back(16'($urandom_range(LEAD_LO, LEAD_HI)));
          units.push_back(16'($urandom_range(TRAIL_LO, TRAIL_HI)));
        end
        UK_LEAD:  units.push_back(16'($urandom_range(LEAD_LO, LEAD_HI)));
        UK_TRAIL: units.push_back(16'($urandom_range(TRAIL_LO, TRAIL_HI)));
        default:  units.push_back(16'($urandom));
      endcase
    end
    foreach (units[i]) queue_unit(units[i], close && (i == units.size() - 1));
    added = units.size();
  endtask

  // everything sent, every result back, then let units with no result settle
  task automatic wait_idle();
    do @(negedge clk);
    while (code_units_q.size() != 0 || tx_have || unit_if.valid || utf8_pending.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.byte_limit <= value;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    limit_reg = value;
    limit_writes++;
  endtask

  initial begin
    int          added;
    int          phase_units;
    logic [31:0] lim;
    unit_if.valid = 1'b0;
    unit_if.code_unit = '0;
    unit_if.end_of_string = 1'b0;
    byte_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.byte_limit = '0;
    rst = 1'b1;
    errors = 0;
    units_sent = 0;
    strings_seen = 0;
    bytes_checked = 0;
    count_only_seen = 0;
    halts = 0;
    limit_writes = 0;
    stall_req = 0;
    stall_len = 0;
    limit_reg = LIMIT_RESET;
    lead_pending = '0;
    held_lead = 1'b0;
    string_bytes = '0;
    string_halted = 1'b0;
    tx_gap_max = 5;
    rx_gap_max = 3;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // length boundaries, valid pairs, lead then plain unit, lone trail, lead at end
    queue_unit(16'h0000, 1'b0);
    queue_unit(16'h007F, 1'b0);
    queue_unit(16'h0080, 1'b0);
    queue_unit(16'h07FF, 1'b0);
    queue_unit(16'h0800, 1'b0);
    queue_unit(16'hFFFF, 1'b0);
    queue_unit(LEAD_LO, 1'b0);
    queue_unit(TRAIL_LO, 1'b0);
    queue_unit(LEAD_HI, 1'b0);
    queue_unit(TRAIL_HI, 1'b0);
    queue_unit(LEAD_LO, 1'b0);
    queue_unit(16'h0041, 1'b0);
    queue_unit(TRAIL_LO, 1'b0);
    queue_unit(LEAD_HI, 1'b1);
    wait_idle();

    // pair fills the limit exactly, later units are dropped, end gives count only
    write_limit(32'd5);
    queue_unit(16'h0041, 1'b0);
    queue_unit(LEAD_LO, 1'b0);
    queue_unit(TRAIL_LO, 1'b0);
    queue_unit(16'h0042, 1'b0);
    queue_unit(16'h0043, 1'b1);
    wait_idle();

    write_limit(32'd0);
    queue_unit(16'h0041, 1'b1);
    wait_idle();

    // held lead does not fit when released
    write_limit(32'd3);
    queue_unit(16'h0041, 1'b0);
    queue_unit(LEAD_LO, 1'b0);
    queue_unit(16'h0042, 1'b0);
    queue_unit(16'h0043, 1'b1);
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      // a string may stay open here, so the new limit lands in mid-string
      wait_idle();
      case (phase)
        0: lim = 32'hFFFF_FFFF;
        1: lim = 32'd0;
        default: begin
          case ($urandom_range(0, 4))
            0: lim = 32'hFFFF_FFFF;
            1: lim = $urandom_range(0, 4);
            2: lim = $urandom_range(5, 40);
            3: lim = $urandom;
            default: lim = $urandom_range(40, 120);
          endcase
        end
      endcase
      write_limit(lim);
      tx_gap_max = $urandom_range(0, 1) * MAX_GAP;
      rx_gap_max = $urandom_range(0, 1) * MAX_GAP;
      if (phase == 3) begin
        tx_gap_max = 0;
        rx_gap_max = 0;
      end else if (phase == 4) begin
        tx_gap_max = MAX_GAP;
        rx_gap_max = MAX_GAP;
      end else if (phase == 2) begin
        // receiver holds off while the sender keeps offering
        tx_gap_max = 0;
        stall_len = 300;
        stall_req = stall_req + 1;
      end
      phase_units = 0;
      while (phase_units < 30) begin
        if ($urandom_range(0, 9) < 7)
          add_string($urandom_range(1, 12), 1'b1,
                     (phase_units < 20) || ($urandom_range(0, 9) < 7), added);
        else
          add_string($urandom_range(1, 5), 1'b0,
                     (phase_units < 20) || ($urandom_range(0, 9) < 7), added);
        phase_units += added;
      end
    end
    queue_unit(16'h0041, 1'b1);
    wait_idle();
    repeat (20) @(posedge clk);
    if (utf8_pending.size() != 0) note_error("results still outstanding at end of run");

    $display("%0d code units in %0d strings, %0d utf-8 bytes and %0d count-only ends checked",
             units_sent, strings_seen, bytes_checked, count_only_seen);
    $display("%0d strings cut by the byte limit over %0d limit settings, %0d mismatches",
             halts, limit_writes, errors);
    if (errors == 0) begin
      $display("utf16_to_utf8_encoder verification clean");
    end else begin
      $display("utf16_to_utf8_encoder verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d results still expected", utf8_pending.size());
    $display("utf16_to_utf8_encoder verification failed");
    $finish;
  end

endmodule

[files.f]
rtl/u2u8_pkg.sv
rtl/u2u8_ifs.sv
rtl/u2u8_queue.sv
rtl/u2u8_front.sv
rtl/u2u8_back.sv
rtl/utf16_to_utf8_encoder.sv
test/tb_top.sv
